// ===== design/sdpg_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpg_pkg
// Shared types, codes and widths for the step/direction pulse generator.
// ----------------------------------------------------------------------------
package sdpg_pkg;

   localparam int DEF_PERIOD_WIDTH = 32;
   localparam int DEF_COUNT_WIDTH  = 16;

   localparam int FUNC_WIDTH      = 2;
   localparam int STEP_REQ_WIDTH  = 16;
   localparam int RATE_REQ_WIDTH  = 18;
   localparam int SPEED_WIDTH     = 17;
   localparam int TCLK_WIDTH      = 27;
   localparam int STEPS_OUT_WIDTH = 16;
   localparam int POS_WIDTH       = 32;
   localparam int CSR_IDX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH  = 27;

   localparam int RATE_CALC_WIDTH = RATE_REQ_WIDTH + 1;
   localparam int RATE_MAG_WIDTH  = RATE_REQ_WIDTH;
   localparam int DIV_STEPS       = TCLK_WIDTH;
   localparam int DIV_CNT_WIDTH   = $clog2(DIV_STEPS);

   localparam logic [FUNC_WIDTH-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_MOVE  = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_DRIVE = 2'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_STOP  = 2'd3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_SPEED = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_SPEED = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TIMER_CLK = 2'd2;

   localparam logic [SPEED_WIDTH-1:0] MAX_SPEED_RST = 17'd20000;
   localparam logic [SPEED_WIDTH-1:0] MIN_SPEED_RST = 17'd100;
   localparam logic [TCLK_WIDTH-1:0]  TIMER_CLK_RST = 27'd1000000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic apply;
      logic div_start;
      logic div_step;
      logic rate_load;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_status_type;

endpackage

// ===== design/sdpg_intf.sv =====
// ----------------------------------------------------------------------------
// sdpg_req_if / sdpg_rsp_if
// Request and response channels of the step/direction pulse generator.
// ----------------------------------------------------------------------------
interface sdpg_req_if;
   logic                                        valid;
   logic                                        ready;
   logic [sdpg_pkg::FUNC_WIDTH-1:0]             func;
   logic signed [sdpg_pkg::STEP_REQ_WIDTH-1:0]  step_request;
   logic signed [sdpg_pkg::RATE_REQ_WIDTH-1:0]  rate_request;

   modport source (output valid, func, step_request, rate_request, input ready);
   modport sink (input valid, func, step_request, rate_request, output ready);
endinterface

interface sdpg_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       step_level;
   logic                                       direction;
   logic                                       running;
   logic                                       step_edge;
   logic [sdpg_pkg::STEPS_OUT_WIDTH-1:0]       steps_left;
   logic signed [sdpg_pkg::POS_WIDTH-1:0]      position_total;

   modport source (output valid, step_level, direction, running, step_edge,
                   steps_left, position_total, input ready);
   modport sink (input valid, step_level, direction, running, step_edge,
                 steps_left, position_total, output ready);
endinterface

// ===== design/step_dir_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// step_dir_pulse_generator
// Step/direction pulse generator for one stepper motor.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch: a timer tick, a move of N steps, a drive at a
// signed speed, or a stop. Each request yields exactly one response on rsp_ch
// carrying the step and direction pin levels, the run flag, the compare-down
// event, the remaining step count and the commanded position.
// Ticks, stops and commands that end with the motor stopped skip the divider:
// the response is valid on the cycle after acceptance, and a new request can
// be accepted every cycle while responses are taken. Drives and nonzero moves
// at a nonzero rate run a restoring divider in ST_DIVIDE, one quotient
// bit per cycle over the 27-bit timer clock, for the timer period; ST_FINISH
// loads the response once the output is free. No request is taken meanwhile.
// The response register decouples the channels: a request is accepted while
// a response is pending as long as that response is taken in the same cycle.
// If the receiver stalls, the response holds and req_ch.ready drops.
// Reset (synchronous) stops the motor, clears position and step count, and
// restores the default speed limits and timer clock. csr_* writes a register
// on any cycle with csr_wr_en high; write only while the block is idle.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator #(
   parameter int PERIOD_WIDTH = sdpg_pkg::DEF_PERIOD_WIDTH,
   parameter int COUNT_WIDTH  = sdpg_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   sdpg_req_if.sink                            req_ch,
   sdpg_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [sdpg_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [sdpg_pkg::CSR_DATA_WIDTH-1:0] csr_wr_data
);

   sdpg_pkg::ctrl_cmd_type  cmd;
   sdpg_pkg::dp_status_type status;

   sdpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdpg_datapath #(
      .PERIOD_WIDTH (PERIOD_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_func           (req_ch.func),
      .req_step_request   (req_ch.step_request),
      .req_rate_request   (req_ch.rate_request),
      .cmd                (cmd),
      .status             (status),
      .rsp_step_level     (rsp_ch.step_level),
      .rsp_direction      (rsp_ch.direction),
      .rsp_running        (rsp_ch.running),
      .rsp_step_edge      (rsp_ch.step_edge),
      .rsp_steps_left     (rsp_ch.steps_left),
      .rsp_position_total (rsp_ch.position_total)
   );

endmodule

// ===== design/sdpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdpg_ctrl
// Request sequencer: accepts requests, runs the period divider, loads results.
// ----------------------------------------------------------------------------
module sdpg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sdpg_pkg::dp_status_type status,
   output sdpg_pkg::ctrl_cmd_type  cmd
);

   sdpg_pkg::state_type                 state_ff, state_in;
   logic [sdpg_pkg::DIV_CNT_WIDTH-1:0]  div_cnt_ff, div_cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                out_free;
   logic                                accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == sdpg_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdpg_pkg::ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         sdpg_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.apply = 1'b1;
               if (status.need_div) begin
                  cmd.div_start = 1'b1;
                  div_cnt_in    = '0;
                  state_in      = sdpg_pkg::ST_DIVIDE;
               end else begin
                  cmd.out_load = 1'b1;
               end
            end
         end
         sdpg_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == sdpg_pkg::DIV_CNT_WIDTH'(sdpg_pkg::DIV_STEPS - 1)) begin
               state_in = sdpg_pkg::ST_FINISH;
            end
         end
         sdpg_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.rate_load = 1'b1;
               cmd.out_load  = 1'b1;
               state_in      = sdpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdpg_pkg::ST_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

// ===== design/sdpg_datapath.sv =====
// ----------------------------------------------------------------------------
// sdpg_datapath
// Configuration, motor state, rate clamp, period divider and result register.
// ----------------------------------------------------------------------------
module sdpg_datapath #(
   parameter int PERIOD_WIDTH = sdpg_pkg::DEF_PERIOD_WIDTH,
   parameter int COUNT_WIDTH  = sdpg_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_wr_en,
   input  logic [sdpg_pkg::CSR_IDX_WIDTH-1:0]         csr_index,
   input  logic [sdpg_pkg::CSR_DATA_WIDTH-1:0]        csr_wr_data,
   input  logic [sdpg_pkg::FUNC_WIDTH-1:0]            req_func,
   input  logic signed [sdpg_pkg::STEP_REQ_WIDTH-1:0] req_step_request,
   input  logic signed [sdpg_pkg::RATE_REQ_WIDTH-1:0] req_rate_request,
   input  sdpg_pkg::ctrl_cmd_type                     cmd,
   output sdpg_pkg::dp_status_type                    status,
   output logic                                       rsp_step_level,
   output logic                                       rsp_direction,
   output logic                                       rsp_running,
   output logic                                       rsp_step_edge,
   output logic [sdpg_pkg::STEPS_OUT_WIDTH-1:0]       rsp_steps_left,
   output logic signed [sdpg_pkg::POS_WIDTH-1:0]      rsp_position_total
);

   localparam int CW  = sdpg_pkg::RATE_CALC_WIDTH;
   localparam int MW  = sdpg_pkg::RATE_MAG_WIDTH;
   localparam int QW  = sdpg_pkg::TCLK_WIDTH;
   localparam int SMW = sdpg_pkg::STEP_REQ_WIDTH + 1;
   localparam int PEW = QW + PERIOD_WIDTH;
   localparam int CEW = SMW + COUNT_WIDTH;

   logic [sdpg_pkg::SPEED_WIDTH-1:0] max_speed_ff;
   logic [sdpg_pkg::SPEED_WIDTH-1:0] min_speed_ff;
   logic [sdpg_pkg::TCLK_WIDTH-1:0]  timer_clk_ff;

   logic                           counting_ff, counting_in;
   logic                           run_ff, run_in;
   logic                           dir_ff, dir_in;
   logic [PERIOD_WIDTH-1:0]        reload_ff, reload_in;
   logic [PERIOD_WIDTH-1:0]        count_ff, count_in;
   logic [COUNT_WIDTH-1:0]         remain_ff, remain_in;
   logic [sdpg_pkg::POS_WIDTH-1:0] pos_ff, pos_in;

   logic          hz_neg_ff;
   logic [MW-1:0] hz_mag_ff;
   logic [MW-1:0] div_rem_ff;
   logic [QW-1:0] div_quot_ff;

   logic signed [CW-1:0] rate_s, max_s, min_s, move_rate, drive_rate;
   logic signed [CW-1:0] drive_abs;
   logic [MW-1:0]        hz_mag;
   logic                 hz_neg;
   logic signed [SMW-1:0] steps_s;
   logic [SMW-1:0]       steps_mag;
   logic [COUNT_WIDTH-1:0] steps_sat;
   logic [MW:0]          rem_shift;
   logic [MW:0]          rem_diff;
   logic                 quot_bit;
   logic [PERIOD_WIDTH-1:0] period_sat;
   logic [PERIOD_WIDTH-1:0] count_dec;
   logic [COUNT_WIDTH-1:0]  remain_dec;
   logic                 edge_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= sdpg_pkg::MAX_SPEED_RST;
         min_speed_ff <= sdpg_pkg::MIN_SPEED_RST;
         timer_clk_ff <= sdpg_pkg::TIMER_CLK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sdpg_pkg::CSR_MAX_SPEED: max_speed_ff <= csr_wr_data[sdpg_pkg::SPEED_WIDTH-1:0];
            sdpg_pkg::CSR_MIN_SPEED: min_speed_ff <= csr_wr_data[sdpg_pkg::SPEED_WIDTH-1:0];
            sdpg_pkg::CSR_TIMER_CLK: timer_clk_ff <= csr_wr_data[sdpg_pkg::TCLK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // clamp
   assign rate_s = CW'(req_rate_request);
   assign max_s  = signed'(CW'(max_speed_ff));
   assign min_s  = signed'(CW'(min_speed_ff));

   always_comb begin
      if (rate_s > max_s) begin
         move_rate = max_s;
      end else if (rate_s < min_s) begin
         move_rate = min_s;
      end else begin
         move_rate = rate_s;
      end

      if (rate_s > max_s) begin
         drive_rate = max_s;
      end else if (rate_s < -max_s) begin
         drive_rate = -max_s;
      end else if (rate_s > 0 && rate_s < min_s) begin
         drive_rate = min_s;
      end else if (rate_s < 0 && rate_s > -min_s) begin
         drive_rate = -min_s;
      end else begin
         drive_rate = rate_s;
      end
      drive_abs = (drive_rate < 0) ? -drive_rate : drive_rate;

      if (req_func == sdpg_pkg::FUNC_MOVE) begin
         hz_mag = MW'(move_rate);
         hz_neg = req_step_request < 0;
      end else begin
         hz_mag = MW'(drive_abs);
         hz_neg = drive_rate < 0;
      end

      status.need_div = (hz_mag != '0) &&
                        ((req_func == sdpg_pkg::FUNC_DRIVE) ||
                         ((req_func == sdpg_pkg::FUNC_MOVE) && (req_step_request != 0)));
   end

   assign steps_s   = SMW'(req_step_request);
   assign steps_mag = (steps_s < 0) ? SMW'(-steps_s) : SMW'(steps_s);
   assign steps_sat = (CEW'(steps_mag) > CEW'({COUNT_WIDTH{1'b1}})) ?
                      {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(steps_mag);

   // restoring divider, one quotient bit per cycle
   assign rem_shift = {div_rem_ff, div_quot_ff[QW-1]};
   assign rem_diff  = rem_shift - {1'b0, hz_mag_ff};
   assign quot_bit  = rem_shift >= {1'b0, hz_mag_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         hz_neg_ff   <= hz_neg;
         hz_mag_ff   <= hz_mag;
         div_rem_ff  <= '0;
         div_quot_ff <= timer_clk_ff;
      end else if (cmd.div_step) begin
         div_rem_ff  <= quot_bit ? rem_diff[MW-1:0] : rem_shift[MW-1:0];
         div_quot_ff <= {div_quot_ff[QW-2:0], quot_bit};
      end
   end

   assign period_sat = (PEW'(div_quot_ff) > PEW'({PERIOD_WIDTH{1'b1}})) ?
                       {PERIOD_WIDTH{1'b1}} : PERIOD_WIDTH'(div_quot_ff);

   assign count_dec  = count_ff - 1'b1;
   assign remain_dec = (remain_ff != '0) ? remain_ff - 1'b1 : '0;

   always_comb begin
      counting_in = counting_ff;
      run_in      = run_ff;
      dir_in      = dir_ff;
      reload_in   = reload_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      pos_in      = pos_ff;
      edge_hit    = 1'b0;

      if (cmd.apply) begin
         unique case (req_func)
            sdpg_pkg::FUNC_TICK: begin
               if (run_ff) begin
                  if (count_ff == '0) begin
                     count_in = reload_ff;
                  end else begin
                     count_in = count_dec;
                     edge_hit = count_dec == (reload_ff >> 1);
                  end
                  if (edge_hit && counting_ff) begin
                     remain_in = remain_dec;
                     if (remain_dec == '0) begin
                        run_in = 1'b0;
                     end
                  end
               end
            end
            sdpg_pkg::FUNC_MOVE: begin
               run_in = 1'b0;
               if (req_step_request == 0) begin
                  remain_in = '0;
               end else begin
                  counting_in = 1'b1;
                  remain_in   = steps_sat;
                  pos_in      = pos_ff + sdpg_pkg::POS_WIDTH'(req_step_request);
               end
            end
            sdpg_pkg::FUNC_DRIVE: begin
               counting_in = 1'b0;
               run_in      = 1'b0;
            end
            sdpg_pkg::FUNC_STOP: begin
               run_in    = 1'b0;
               remain_in = '0;
            end
            default: ;
         endcase
      end

      if (cmd.rate_load) begin
         dir_in    = hz_neg_ff;
         reload_in = period_sat;
         count_in  = period_sat;
         run_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counting_ff <= 1'b0;
         run_ff      <= 1'b0;
         dir_ff      <= 1'b0;
         reload_ff   <= '0;
         count_ff    <= '0;
         remain_ff   <= '0;
         pos_ff      <= '0;
      end else begin
         counting_ff <= counting_in;
         run_ff      <= run_in;
         dir_ff      <= dir_in;
         reload_ff   <= reload_in;
         count_ff    <= count_in;
         remain_ff   <= remain_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_step_level     <= run_in && (count_in > (reload_in >> 1));
         rsp_direction      <= dir_in;
         rsp_running        <= run_in;
         rsp_step_edge      <= edge_hit;
         rsp_steps_left     <= sdpg_pkg::STEPS_OUT_WIDTH'(remain_in);
         rsp_position_total <= signed'(pos_in);
      end
   end

endmodule

// ===== design/sdpg_checker.sv =====
// ----------------------------------------------------------------------------
// sdpg_checker
// Port-level checks for the step/direction pulse generator.
// ----------------------------------------------------------------------------
module sdpg_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [sdpg_pkg::FUNC_WIDTH-1:0]       req_func,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_step_level,
   input logic                                  rsp_running,
   input logic [sdpg_pkg::STEPS_OUT_WIDTH-1:0]  rsp_steps_left
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_level_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_step_level || rsp_running)
      else $error("step pin high while stopped");

   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == sdpg_pkg::FUNC_TICK) |=> rsp_valid)
      else $error("tick response late");

   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == sdpg_pkg::FUNC_STOP)
      |=> rsp_valid && !rsp_running && (rsp_steps_left == '0))
      else $error("stop response wrong");

endmodule

bind step_dir_pulse_generator sdpg_checker u_sdpg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_func       (req_ch.func),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_step_level (rsp_ch.step_level),
   .rsp_running    (rsp_ch.running),
   .rsp_steps_left (rsp_ch.steps_left)
);
